// ===== rtl/pcm_frame_downmix_unit_assert.svh =====
// Assertion macros for the downmix unit.
`ifndef PCM_FRAME_DOWNMIX_UNIT_ASSERT_SVH
`define PCM_FRAME_DOWNMIX_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PCMDM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PCMDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PCMDM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PCMDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/pcmdm_pkg.sv =====
`timescale 1ns / 1ps

package pcmdm_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 8;
   localparam int DIVISOR_W = 6;

   // register indexes
   localparam logic [2:0] CSR_SAMPLE_WIDTH_CODE = 3'd0;
   localparam logic [2:0] CSR_CHANNEL_COUNT     = 3'd1;
   localparam logic [2:0] CSR_BLOCK_ALIGN       = 3'd2;
   localparam logic [2:0] CSR_CHUNK_BYTES       = 3'd3;
   localparam logic [2:0] CSR_FILE_REST_BYTES   = 3'd4;

   // sample width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_24 = 2'd2;
   localparam logic [1:0] WIDTH_32 = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ALIGN     = 2'd1;
   localparam logic [1:0] ERR_PARTIAL   = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED = 2'd3;

   localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CHUNK_DIV,
      ST_SAMPLE,
      ST_MIX_DIV,
      ST_FRAME,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RUN,
      PH_DONE,
      PH_ERR
   } phase_type;

   typedef struct packed {
      logic signed [31:0] mono_sample;
      logic signed [31:0] running_min;
      logic signed [31:0] running_max;
      logic [31:0]        frame_number;
      logic               last_frame;
      logic [1:0]         error_code;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // left-align a raw little-endian sample into Q1.31
   function automatic logic signed [31:0] to_q31(logic [31:0] raw, logic [1:0] code);
      case (code)
         WIDTH_8:  return {~raw[7], raw[6:0], 24'd0};
         WIDTH_16: return {raw[15:0], 16'd0};
         WIDTH_24: return {raw[23:0], 8'd0};
         default:  return raw;
      endcase
   endfunction

endpackage

// ===== rtl/pcmdm_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, small divisor.
module pcmdm_div #(
   parameter int DIV_W = 35
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIV_W-1:0]                  dividend,
   input  logic [pcmdm_pkg::DIVISOR_W-1:0]   divisor,
   output pcmdm_pkg::div_status_type         status,
   output logic [DIV_W-1:0]                  quotient,
   output logic [pcmdm_pkg::DIVISOR_W-1:0]   remainder
);
   import pcmdm_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/pcmdm_rsp_buf.sv =====
`timescale 1ns / 1ps

// Output register: holds one result word until the receiver takes it.
module pcmdm_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  pcmdm_pkg::rsp_word_type load_word,
   output logic                    ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pcmdm_pkg::rsp_word_type rsp_word
);
   import pcmdm_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   always_comb begin
      ready    = !valid_ff || !rsp_stall;
      valid_in = valid_ff && rsp_stall;
      word_in  = word_ff;
      if (load && ready) begin
         valid_in = 1'b1;
         word_in  = load_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/pcm_frame_downmix_unit.sv =====
// PCM data chunk to mono downmix.
// Input: one byte of the data chunk per word on req_* (valid/stall). Bytes
// build little-endian samples of 8/16/24/32 bits, converted to Q1.31; the
// channels of a frame are summed and divided by the channel count.
// Output: one word per frame on rsp_* with the mono value, running min/max,
// frame index and last-frame flag; or one error word, after which (and after
// the last frame) further bytes are taken and dropped.
// Configuration: csr_write/csr_index/csr_wdata, written while idle.
// Timing: a byte that finishes a frame waits for the shared bit-serial
// divider, DIV_W = 32 + log2(MAX_CHANNELS); the first byte of a chunk also
// waits for the frame-count divide on that divider.
// req_stall is high while a byte is in work.
// A result sits in an output register; while rsp_stall holds it, the block
// still finishes the next byte and only waits when it has a second result.
// Reset (synchronous) restores the register defaults and the start-of-chunk
// state; no clearing pass is needed.
`timescale 1ns / 1ps
`include "pcm_frame_downmix_unit_assert.svh"

module pcm_frame_downmix_unit #(
   parameter int MAX_CHANNELS = pcmdm_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_mono_sample,
   output logic signed [31:0] rsp_running_min,
   output logic signed [31:0] rsp_running_max,
   output logic [31:0]        rsp_frame_number,
   output logic               rsp_last_frame,
   output logic [1:0]         rsp_error_code
);
   import pcmdm_pkg::*;

   localparam int SUM_W = 32 + $clog2(MAX_CHANNELS);
   localparam int CH_W  = $clog2(MAX_CHANNELS + 1);

   // configuration
   logic [1:0]  width_code_ff;
   logic [3:0]  channel_count_ff;
   logic [15:0] block_align_ff;
   logic [31:0] chunk_bytes_ff;
   logic [31:0] file_rest_ff;

   // work state
   state_type               state_ff, state_in;
   phase_type               phase_ff, phase_in;
   logic [7:0]              byte_ff, byte_in;
   logic [1:0]              pos_ff, pos_in;
   logic [31:0]             asm_ff, asm_in;
   logic [CH_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic [31:0]             frames_left_ff, frames_left_in;
   logic [31:0]             rest_ff, rest_in;
   logic [31:0]             frame_cnt_ff, frame_cnt_in;
   logic signed [31:0]      min_ff, min_in;
   logic signed [31:0]      max_ff, max_in;
   logic signed [31:0]      mono_ff, mono_in;
   rsp_word_type            res_ff, res_in;

   // combinational helpers
   logic [2:0]              bytes;
   logic [6:0]              align_prod;
   logic                    align_ok;
   logic [CH_W-1:0]         nch;
   logic [31:0]             asm_next;
   logic [2:0]              pos_plus;
   logic [CH_W:0]           idx_plus;
   logic signed [SUM_W-1:0] sum_new;
   logic [SUM_W-1:0]        sum_abs;
   logic [31:0]             q32;
   logic [31:0]             fl_dec;

   // shared divider
   logic                   div_start;
   logic [SUM_W-1:0]       div_dividend;
   logic [DIVISOR_W-1:0]   div_divisor;
   div_status_type         div_stat;
   logic [SUM_W-1:0]       div_quo;
   logic [DIVISOR_W-1:0]   div_rem;

   logic                   buf_load;
   logic                   buf_ready;
   rsp_word_type           rsp_word;

   pcmdm_div #(
      .DIV_W (SUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   pcmdm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (buf_load),
      .load_word (res_ff),
      .ready     (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_mono_sample  = rsp_word.mono_sample;
   assign rsp_running_min  = rsp_word.running_min;
   assign rsp_running_max  = rsp_word.running_max;
   assign rsp_frame_number = rsp_word.frame_number;
   assign rsp_last_frame   = rsp_word.last_frame;
   assign rsp_error_code   = rsp_word.error_code;

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_code_ff    <= WIDTH_16;
         channel_count_ff <= 4'd1;
         block_align_ff   <= 16'd2;
         chunk_bytes_ff   <= '0;
         file_rest_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SAMPLE_WIDTH_CODE: width_code_ff    <= csr_wdata[1:0];
            CSR_CHANNEL_COUNT:     channel_count_ff <= csr_wdata[3:0];
            CSR_BLOCK_ALIGN:       block_align_ff   <= csr_wdata[15:0];
            CSR_CHUNK_BYTES:       chunk_bytes_ff   <= csr_wdata;
            CSR_FILE_REST_BYTES:   file_rest_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      bytes      = {1'b0, width_code_ff} + 3'd1;
      align_prod = 7'(channel_count_ff) * 7'(bytes);
      align_ok   = (channel_count_ff != 4'd0)
                   && (32'(channel_count_ff) <= 32'(MAX_CHANNELS))
                   && (block_align_ff == 16'(align_prod));
      if (32'(channel_count_ff) > 32'(MAX_CHANNELS)) begin
         nch = CH_W'(MAX_CHANNELS);
      end else if (channel_count_ff == 4'd0) begin
         nch = CH_W'(1);
      end else begin
         nch = CH_W'(channel_count_ff);
      end
      asm_next = asm_ff | (32'(byte_ff) << {pos_ff, 3'b000});
      pos_plus = {1'b0, pos_ff} + 3'd1;
      idx_plus = {1'b0, idx_ff} + (CH_W + 1)'(1);
      sum_new  = sum_ff + SUM_W'(to_q31(asm_next, width_code_ff));
      sum_abs  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
      q32      = div_quo[31:0];
      fl_dec   = frames_left_ff - 32'd1;
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      byte_in        = byte_ff;
      pos_in         = pos_ff;
      asm_in         = asm_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      neg_in         = neg_ff;
      frames_left_in = frames_left_ff;
      rest_in        = rest_ff;
      frame_cnt_in   = frame_cnt_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      mono_in        = mono_ff;
      res_in         = res_ff;
      div_start      = 1'b0;
      div_dividend   = SUM_W'(chunk_bytes_ff);
      div_divisor    = block_align_ff[DIVISOR_W-1:0];
      buf_load       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               case (phase_ff)
                  PH_IDLE: state_in = ST_CHECK;
                  PH_RUN:  state_in = ST_SAMPLE;
                  default: state_in = ST_IDLE;  // ended: drop the byte
               endcase
            end
         end

         ST_CHECK: begin
            if (!align_ok) begin
               res_in   = '{32'sd0, min_ff, max_ff, frame_cnt_ff, 1'b0, ERR_ALIGN};
               phase_in = PH_ERR;
               state_in = ST_EMIT;
            end else begin
               // block_align equals the product here, so it fits the divisor
               div_start = 1'b1;
               state_in  = ST_CHUNK_DIV;
            end
         end

         ST_CHUNK_DIV: begin
            if (div_stat.done) begin
               if (div_rem != '0) begin
                  res_in   = '{32'sd0, min_ff, max_ff, frame_cnt_ff, 1'b0, ERR_PARTIAL};
                  phase_in = PH_ERR;
                  state_in = ST_EMIT;
               end else begin
                  frames_left_in = q32;
                  rest_in        = file_rest_ff;
                  pos_in         = '0;
                  asm_in         = '0;
                  idx_in         = '0;
                  sum_in         = '0;
                  if (q32 == 32'd0) begin
                     phase_in = PH_DONE;
                     state_in = ST_IDLE;
                  end else begin
                     phase_in = PH_RUN;
                     state_in = ST_SAMPLE;
                  end
               end
            end
         end

         ST_SAMPLE: begin
            asm_in = asm_next;
            if (pos_plus < bytes) begin
               pos_in   = pos_ff + 2'd1;
               state_in = ST_IDLE;
            end else begin
               pos_in = '0;
               if (rest_ff < 32'(bytes)) begin
                  res_in   = '{32'sd0, min_ff, max_ff, frame_cnt_ff, 1'b0, ERR_TRUNCATED};
                  phase_in = PH_ERR;
                  state_in = ST_EMIT;
               end else begin
                  rest_in = rest_ff - 32'(bytes);
                  asm_in  = '0;
                  sum_in  = sum_new;
                  if (idx_plus < {1'b0, nch}) begin
                     idx_in   = idx_ff + CH_W'(1);
                     state_in = ST_IDLE;
                  end else begin
                     // frame complete: divide the magnitude, fix sign later
                     neg_in       = sum_new[SUM_W-1];
                     div_start    = 1'b1;
                     div_dividend = sum_abs;
                     div_divisor  = DIVISOR_W'(nch);
                     state_in     = ST_MIX_DIV;
                  end
               end
            end
         end

         ST_MIX_DIV: begin
            if (div_stat.done) begin
               mono_in  = neg_ff ? (~q32 + 32'd1) : q32;
               state_in = ST_FRAME;
            end
         end

         ST_FRAME: begin
            min_in = (mono_ff < min_ff) ? mono_ff : min_ff;
            max_in = (mono_ff > max_ff) ? mono_ff : max_ff;
            frames_left_in = fl_dec;
            res_in.mono_sample  = mono_ff;
            res_in.running_min  = (mono_ff < min_ff) ? mono_ff : min_ff;
            res_in.running_max  = (mono_ff > max_ff) ? mono_ff : max_ff;
            res_in.frame_number = frame_cnt_ff;
            res_in.last_frame   = (fl_dec == 32'd0);
            res_in.error_code   = ERR_NONE;
            frame_cnt_in = frame_cnt_ff + 32'd1;
            idx_in       = '0;
            sum_in       = '0;
            if (fl_dec == 32'd0) begin
               phase_in = PH_DONE;
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (buf_ready) begin
               buf_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_IDLE;
         pos_ff         <= '0;
         asm_ff         <= '0;
         idx_ff         <= '0;
         sum_ff         <= '0;
         frames_left_ff <= '0;
         rest_ff        <= '0;
         frame_cnt_ff   <= '0;
         min_ff         <= Q31_MAX;
         max_ff         <= Q31_MIN;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         asm_ff         <= asm_in;
         idx_ff         <= idx_in;
         sum_ff         <= sum_in;
         frames_left_ff <= frames_left_in;
         rest_ff        <= rest_in;
         frame_cnt_ff   <= frame_cnt_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
      end
      byte_ff <= byte_in;
      neg_ff  <= neg_in;
      mono_ff <= mono_in;
      res_ff  <= res_in;
   end

   `PCMDM_ASSERT_IMPL(a_err_word_phase, clock, reset,
      rsp_valid && (rsp_error_code != ERR_NONE), phase_ff == PH_ERR, "error word outside error phase")
   `PCMDM_ASSERT_IMPL(a_last_word_phase, clock, reset,
      rsp_valid && rsp_last_frame, phase_ff == PH_DONE, "last frame word outside done phase")
   `PCMDM_ASSERT_IMPL(a_div_start_idle, clock, reset,
      div_start, !div_stat.busy, "divider restarted while busy")
   `PCMDM_ASSERT_NEXT(a_run_byte_sampled, clock, reset,
      req_valid && !req_stall && (phase_ff == PH_RUN), state_ff == ST_SAMPLE,
      "running byte not taken as sample data")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import pcmdm_pkg::*;

   localparam int ITEM_TARGET = 1700;
   localparam int SETTLE_CYCLES = 100;

   // predicts the mono frame words and error words of one chunk, byte by byte
   class frame_mix_board;
      logic [1:0]         width_code;
      logic [3:0]         chan_reg;
      logic [15:0]        align_reg;
      logic [31:0]        chunk_reg;
      logic [31:0]        rest_reg;
      logic [1:0]         byte_pos;
      logic [31:0]        assembly;
      int                 chan_idx;
      longint             chan_sum;
      logic [31:0]        frames_left;
      logic [31:0]        rest_left;
      logic [31:0]        frame_ctr;
      logic signed [31:0] min_q;
      logic signed [31:0] max_q;
      phase_type          phase;
      rsp_word_type       pending_words[$];
      int                 words_seen;
      int                 mismatches;

      function new();
         width_code = WIDTH_16;
         chan_reg = 4'd1;
         align_reg = 16'd2;
         chunk_reg = '0;
         rest_reg = '0;
         byte_pos = '0;
         assembly = '0;
         chan_idx = 0;
         chan_sum = 0;
         frames_left = '0;
         rest_left = '0;
         frame_ctr = '0;
         min_q = Q31_MAX;
         max_q = Q31_MIN;
         phase = PH_IDLE;
         words_seen = 0;
         mismatches = 0;
      endfunction

      static function int active_channels(logic [3:0] c);
         if (c < 1) return 1;
         if (c > pcmdm_pkg::MAX_CHANNELS_DEFAULT) return pcmdm_pkg::MAX_CHANNELS_DEFAULT;
         return int'(c);
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_SAMPLE_WIDTH_CODE: width_code = v[1:0];
            CSR_CHANNEL_COUNT:     chan_reg = v[3:0];
            CSR_BLOCK_ALIGN:       align_reg = v[15:0];
            CSR_CHUNK_BYTES:       chunk_reg = v;
            CSR_FILE_REST_BYTES:   rest_reg = v;
            default: ;
         endcase
      endfunction

      function longint sample_q31(logic [31:0] raw);
         shortint            s16;
         logic signed [23:0] s24;
         int                 s32;
         s16 = raw[15:0];
         s24 = raw[23:0];
         s32 = raw;
         case (width_code)
            WIDTH_8:  return (longint'(raw[7:0]) - 128) * 16777216;
            WIDTH_16: return longint'(s16) * 65536;
            WIDTH_24: return longint'(s24) * 256;
            default:  return longint'(s32);
         endcase
      endfunction

      function void post_error(logic [1:0] code);
         rsp_word_type w;
         w.mono_sample = '0;
         w.running_min = min_q;
         w.running_max = max_q;
         w.frame_number = frame_ctr;
         w.last_frame = 1'b0;
         w.error_code = code;
         pending_words.push_back(w);
         phase = PH_ERR;
      endfunction

      function void take_byte(logic [7:0] b);
         int           nbytes;
         int           nch;
         longint       mono;
         rsp_word_type w;
         nbytes = int'(width_code) + 1;
         if (phase == PH_DONE || phase == PH_ERR) return;
         if (phase == PH_IDLE) begin
            // header sanity is only looked at on the first byte
            if (chan_reg < 1 || chan_reg > pcmdm_pkg::MAX_CHANNELS_DEFAULT ||
                32'(align_reg) != 32'(chan_reg) * 32'(nbytes)) begin
               post_error(ERR_ALIGN);
               return;
            end
            if (chunk_reg % 32'(align_reg) != 0) begin
               post_error(ERR_PARTIAL);
               return;
            end
            frames_left = chunk_reg / 32'(align_reg);
            rest_left = rest_reg;
            byte_pos = '0;
            assembly = '0;
            chan_idx = 0;
            chan_sum = 0;
            if (frames_left == 0) begin
               phase = PH_DONE;
               return;
            end
            phase = PH_RUN;
         end
         assembly = assembly | (32'(b) << (8 * int'(byte_pos)));
         if (int'(byte_pos) + 1 < nbytes) begin
            byte_pos = byte_pos + 2'd1;
            return;
         end
         byte_pos = '0;
         if (rest_left < 32'(nbytes)) begin
            post_error(ERR_TRUNCATED);
            return;
         end
         rest_left = rest_left - 32'(nbytes);
         chan_sum = chan_sum + sample_q31(assembly);
         assembly = '0;
         nch = active_channels(chan_reg);
         if (chan_idx + 1 < nch) begin
            chan_idx++;
            return;
         end
         // signed divide truncates toward zero
         mono = chan_sum / longint'(nch);
         chan_idx = 0;
         chan_sum = 0;
         if (mono < longint'(min_q)) min_q = mono[31:0];
         if (mono > longint'(max_q)) max_q = mono[31:0];
         frames_left = frames_left - 32'd1;
         w.mono_sample = mono[31:0];
         w.running_min = min_q;
         w.running_max = max_q;
         w.frame_number = frame_ctr;
         w.last_frame = (frames_left == 0);
         w.error_code = ERR_NONE;
         pending_words.push_back(w);
         frame_ctr = frame_ctr + 32'd1;
         if (frames_left == 0) phase = PH_DONE;
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         words_seen++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: mono %0d frame %0d last %0d err %0d",
                        got.mono_sample, got.frame_number, got.last_frame, got.error_code);
            return;
         end
         want = pending_words.pop_front();
         if (got.mono_sample !== want.mono_sample || got.running_min !== want.running_min ||
             got.running_max !== want.running_max ||
             got.frame_number !== want.frame_number ||
             got.last_frame !== want.last_frame || got.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("word %0d expected: mono %0d min %0d max %0d frame %0d last %0d err %0d",
                        words_seen, want.mono_sample, want.running_min, want.running_max,
                        want.frame_number, want.last_frame, want.error_code);
               $display("word %0d actual:   mono %0d min %0d max %0d frame %0d last %0d err %0d",
                        words_seen, got.mono_sample, got.running_min, got.running_max,
                        got.frame_number, got.last_frame, got.error_code);
            end
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void close_out();
         if (pending_words.size() != 0) begin
            $display("%0d expected words never arrived", pending_words.size());
            mismatches += pending_words.size();
         end
      endfunction
   endclass

   typedef struct {
      logic [1:0] code;
      logic [3:0] chan;
      int         frames;
      bit         scripted;
   } mix_segment_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_mono_sample;
   logic signed [31:0] rsp_running_min;
   logic signed [31:0] rsp_running_max;
   logic [31:0]        rsp_frame_number;
   logic               rsp_last_frame;
   logic [1:0]         rsp_error_code;
   rsp_word_type       rsp_word;

   frame_mix_board     board = new();
   mix_segment_type    run_plan[$];
   logic [7:0]         opening_bytes[$];
   int                 bytes_sent = 0;

   pcm_frame_downmix_unit #(
      .MAX_CHANNELS(MAX_CHANNELS_DEFAULT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mono_sample(rsp_mono_sample),
      .rsp_running_min(rsp_running_min),
      .rsp_running_max(rsp_running_max),
      .rsp_frame_number(rsp_frame_number),
      .rsp_last_frame(rsp_last_frame),
      .rsp_error_code(rsp_error_code)
   );

   assign rsp_word = {rsp_mono_sample, rsp_running_min, rsp_running_max, rsp_frame_number,
                      rsp_last_frame, rsp_error_code};

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] stray_value(logic [31:0] mask);
      case ($urandom_range(0, 2))
         0: return '0;
         1: return mask;
         default: return $urandom & mask;
      endcase
   endfunction

   task automatic csr_put(input logic [2:0] idx, input logic [31:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      board.set_reg(idx, val);
   endtask

   task automatic offer_byte(input logic [7:0] b);
      while (!(bytes_sent >= 700 && bytes_sent < 1000) && $urandom_range(0, 99) < 23) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      do @(posedge clock); while (req_stall);
      board.take_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      // a byte that ends in no word may still be in work
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: random stalls, one long hold-off, one stretch with none
   initial begin
      int hold_cycles;
      bit held_once;
      hold_cycles = 0;
      held_once = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && board.words_seen >= 60) begin
            hold_cycles = 400;
            held_once = 1'b1;
         end
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else if (board.words_seen >= 150 && board.words_seen < 260) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < 23);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_word);
   end

   initial begin
      mix_segment_type seg;
      int              n;
      int              r;
      int              nrand;
      int              planned;
      int unsigned     total_frames;
      int unsigned     total_bytes;
      int unsigned     last_bytes;
      int unsigned     align0;
      logic [31:0]     rest_value;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_SAMPLE_WIDTH_CODE;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data_byte = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // opening words: 8-bit extremes, 32-bit full scale, a negative odd divide
      opening_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F,
                        8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80,
                        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                        8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
      seg = '{WIDTH_8, 4'd1, 4, 1'b1};
      run_plan.push_back(seg);
      seg = '{WIDTH_32, 4'd2, 2, 1'b1};
      run_plan.push_back(seg);
      seg = '{WIDTH_16, 4'd3, 1, 1'b1};
      run_plan.push_back(seg);
      planned = opening_bytes.size();
      nrand = 0;
      while (planned < ITEM_TARGET) begin
         seg.code = 2'($urandom_range(0, 3));
         r = $urandom_range(0, 19);
         if (r == 0) seg.chan = 4'd0;
         else if (r == 1) seg.chan = 4'($urandom_range(9, 15));
         else seg.chan = 4'($urandom_range(1, 8));
         // out-of-range counts clamp while running
         if (nrand == 0) seg.chan = 4'd15;
         if (nrand == 1) seg.chan = 4'd0;
         if (nrand == 2) begin
            seg.chan = 4'd8;
            seg.code = WIDTH_32;
         end
         seg.frames = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
         seg.scripted = 1'b0;
         run_plan.push_back(seg);
         planned += seg.frames * frame_mix_board::active_channels(seg.chan) *
                    (int'(seg.code) + 1);
         nrand++;
      end

      total_frames = 0;
      total_bytes = 0;
      last_bytes = 0;
      foreach (run_plan[i]) begin
         last_bytes = run_plan[i].frames * frame_mix_board::active_channels(run_plan[i].chan) *
                      (int'(run_plan[i].code) + 1);
         total_frames += run_plan[i].frames;
         total_bytes += last_bytes;
      end
      // the chunk ends either on its last frame or short of file bytes
      if ($urandom_range(0, 1) == 1)
         rest_value = total_bytes - $urandom_range(1, last_bytes);
      else if ($urandom_range(0, 1) == 1)
         rest_value = 32'hFFFF_FFFF;
      else
         rest_value = total_bytes + $urandom_range(0, 3);
      align0 = frame_mix_board::active_channels(run_plan[0].chan) *
               (int'(run_plan[0].code) + 1);

      csr_put(CSR_SAMPLE_WIDTH_CODE, 32'(run_plan[0].code));
      csr_put(CSR_CHANNEL_COUNT, 32'(run_plan[0].chan));
      csr_put(CSR_BLOCK_ALIGN, align0);
      csr_put(CSR_CHUNK_BYTES, total_frames * align0);
      csr_put(CSR_FILE_REST_BYTES, rest_value);

      foreach (run_plan[i]) begin
         if (i > 0) begin
            drain_results();
            csr_put(CSR_SAMPLE_WIDTH_CODE, 32'(run_plan[i].code));
            csr_put(CSR_CHANNEL_COUNT, 32'(run_plan[i].chan));
            // header registers are latched at the first byte; later writes must not matter
            case ($urandom_range(0, 5))
               0: csr_put(CSR_BLOCK_ALIGN, stray_value(32'h0000_FFFF));
               1: csr_put(CSR_CHUNK_BYTES, stray_value(32'hFFFF_FFFF));
               2: csr_put(CSR_FILE_REST_BYTES, stray_value(32'hFFFF_FFFF));
               default: ;
            endcase
         end
         n = run_plan[i].frames * frame_mix_board::active_channels(run_plan[i].chan) *
             (int'(run_plan[i].code) + 1);
         repeat (n) begin
            if (run_plan[i].scripted) offer_byte(opening_bytes.pop_front());
            else offer_byte(pick_byte());
         end
      end
      // bytes past the end of the chunk are dropped
      repeat (8) offer_byte(pick_byte());
      drain_results();
      board.close_out();
      if (board.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
